// ===== rtl/core/mgdm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, widths and helpers for the staggered-grid divergence block.
// Used by the top level and the divider; no dependencies.
package mgdm_pkg;
	localparam int MAX_X      = 64;
	localparam int MAX_Y      = 64;
	localparam int MAX_Z      = 64;
	localparam int VEL_WIDTH  = 32;
	localparam int RING_DEPTH = MAX_X * MAX_Y;
	localparam int ADDR_W     = $clog2(RING_DEPTH);
	localparam int SPAN_W     = $clog2(RING_DEPTH + 1);
	localparam int WORD_W     = 3 * VEL_WIDTH + 1;
	localparam int SIZE_W     = 7;
	localparam int CX_W       = $clog2(MAX_X);
	localparam int CY_W       = $clog2(MAX_Y);
	localparam int CZ_W       = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
	localparam int DIV_W      = 36;
	localparam int MEAN_W     = 35;
	localparam int SUM_W      = 54;
	localparam int CNT_W      = 19;
	localparam int STEP_W     = $clog2(SUM_W + 1);

	localparam logic [1:0] REG_SIZE_X  = 2'd0;
	localparam logic [1:0] REG_SIZE_Y  = 2'd1;
	localparam logic [1:0] REG_SIZE_Z  = 2'd2;
	localparam logic [1:0] REG_THREE_D = 2'd3;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] mx);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0)
			r = SIZE_W'(1);
		else if (v > mx)
			r = mx;
		return r;
	endfunction
endpackage

// ===== rtl/core/mgdm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mgdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/mgdm_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the grid-end mean.
// Depends on mgdm_pkg.
module mgdm_div import mgdm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             busy,
	output logic [SUM_W-1:0] quotient
);
	logic [SUM_W-1:0]  q_q;
	logic [CNT_W-1:0]  r_q;
	logic [CNT_W-1:0]  d_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic [CNT_W:0]    shifted;
	logic              ge;

	assign shifted = {r_q, q_q[SUM_W-1]};
	assign ge      = shifted >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_W'(SUM_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - STEP_W'(1);
			busy_q <= cnt_q != STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[SUM_W-2:0], ge};
			r_q <= ge ? CNT_W'(shifted - {1'b0, d_q}) : CNT_W'(shifted);
		end
	end

	assign busy     = busy_q;
	assign quotient = q_q;
endmodule

// ===== rtl/core/mac_grid_divergence_metric.sv =====
`timescale 1ns / 1ps
// Streaming divergence stencil on a staggered grid, Q16.16.
// Depends on mgdm_pkg, mgdm_ram, mgdm_div.
//
// Usage:
//  Cells enter on in_valid/in_stall in raster order, x fastest. Each accepted
//  item produces exactly one result on out_valid/out_stall: the divergence of
//  the cell one slice (3D) or one row (2D) back, div_valid low during warm-up.
//  Item sequence: an accepted cell steps through S_RB, S_RC and S_CALC, set
//  by three reads of the single ring memory (own entry, x neighbor, y
//  neighbor) and the write-back; the next cell waits until it is done.
//  On the final cell of the grid the mean absolute divergence is formed by a
//  bit-serial divider, which is skipped when no interior cell is fluid.
//  The result waits in an output register; the next item is accepted while
//  it is stalled, and its write-back waits until the register frees up.
//  Reset: sizes 64x64x64, 3D, position and accumulators cleared; ring
//  contents are undefined until written; warm-up reads them unwritten, with
//  div_valid low. Any register write over APB restarts the grid.
module mac_grid_divergence_metric import mgdm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [3:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [31:0]       vel_x,
	input  logic signed [31:0]       vel_y,
	input  logic signed [31:0]       vel_z,
	input  logic                     is_fluid,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     div_valid,
	output logic signed [DIV_W-1:0]  divergence,
	output logic                     grid_done,
	output logic [MEAN_W-1:0]        mean_abs_divergence,
	output logic                     no_fluid
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RB   = 2'd1;
	localparam logic [1:0] S_RC   = 2'd2;
	localparam logic [1:0] S_CALC = 2'd3;

	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic              three_d_q;
	logic [1:0]        state_q;
	logic              div_phase_q;
	logic [CX_W-1:0]   px_q;
	logic [CY_W-1:0]   py_q;
	logic [CZ_W-1:0]   pz_q;
	logic [ADDR_W-1:0] widx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic signed [VEL_WIDTH-1:0] cx_q, cy_q, cz_q;
	logic              cf_q;
	logic [WORD_W-1:0] wa_q, wb_q;

	logic              out_valid_q, div_valid_q, grid_done_q, no_fluid_q;
	logic [DIV_W-1:0]  divergence_q;
	logic [MEAN_W-1:0] mean_q;

	logic              cfg_wr, accept, free, go_calc, finish;
	logic [SIZE_W-1:0] sx, sy, sz;
	logic [SPAN_W-1:0] span, bsum, csum;
	logic [ADDR_W-1:0] addr_b, addr_c, raddr;
	logic [WORD_W-1:0] rdata, wdata;
	logic signed [VEL_WIDTH-1:0] xq, yq, zq, xn, yn;
	logic              fq, use_cur_y, valid_div, inner, hit, last;
	logic [SIZE_W-1:0] ix, jq, kq;
	logic signed [DIV_W-1:0] dsum, dval;
	logic [DIV_W-1:0]  absv;
	logic [SUM_W-1:0]  new_sum;
	logic [CNT_W-1:0]  new_cnt;
	logic              div_busy, div_start;
	logic [SUM_W-1:0]  quot;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_SIZE_X:  prdata = {25'd0, size_x_q};
			REG_SIZE_Y:  prdata = {25'd0, size_y_q};
			REG_SIZE_Z:  prdata = {25'd0, size_z_q};
			REG_THREE_D: prdata = {31'd0, three_d_q};
			default:     prdata = '0;
		endcase
	end

	assign sx   = clamp_size(size_x_q, SIZE_W'(MAX_X));
	assign sy   = clamp_size(size_y_q, SIZE_W'(MAX_Y));
	assign sz   = three_d_q ? clamp_size(size_z_q, SIZE_W'(MAX_Z)) : SIZE_W'(1);
	assign span = three_d_q ? SPAN_W'(sx * sy) : SPAN_W'(sx);

	assign bsum   = SPAN_W'(widx_q) + SPAN_W'(1);
	assign csum   = SPAN_W'(widx_q) + SPAN_W'(sx);
	assign addr_b = (bsum >= span) ? ADDR_W'(bsum - span) : ADDR_W'(bsum);
	assign addr_c = (csum >= span) ? ADDR_W'(csum - span) : ADDR_W'(csum);

	always_comb begin
		case (state_q)
			S_RB:    raddr = addr_b;
			S_RC:    raddr = addr_c;
			S_CALC:  raddr = addr_c;
			default: raddr = widx_q;
		endcase
	end

	assign in_stall = state_q != S_IDLE || div_phase_q;
	assign accept   = in_valid && !in_stall;
	assign free     = !out_valid_q || !out_stall;
	assign go_calc  = state_q == S_CALC && !div_phase_q && free;
	assign finish   = div_phase_q && !div_busy && free;

	assign wdata = {cf_q, cz_q, cy_q, cx_q};

	mgdm_ram #(.WIDTH(WORD_W), .DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (go_calc),
		.waddr (widx_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign xq = wa_q[VEL_WIDTH-1:0];
	assign yq = wa_q[2*VEL_WIDTH-1:VEL_WIDTH];
	assign zq = wa_q[3*VEL_WIDTH-1:2*VEL_WIDTH];
	assign fq = wa_q[WORD_W-1];
	assign xn = wb_q[VEL_WIDTH-1:0];
	assign use_cur_y = !three_d_q || sy == SIZE_W'(1);
	assign yn = use_cur_y ? cy_q : rdata[2*VEL_WIDTH-1:VEL_WIDTH];

	always_comb begin
		dsum = DIV_W'(xn) - DIV_W'(xq) + DIV_W'(yn) - DIV_W'(yq);
		if (three_d_q)
			dsum = dsum + DIV_W'(cz_q) - DIV_W'(zq);
	end

	assign ix = SIZE_W'(px_q);
	assign jq = three_d_q ? SIZE_W'(py_q) : SIZE_W'(py_q) - SIZE_W'(1);
	assign kq = SIZE_W'(pz_q) - SIZE_W'(1);
	assign valid_div = three_d_q ? pz_q != '0 : py_q != '0;
	assign inner = ix >= SIZE_W'(1) && ix + SIZE_W'(1) < sx
		&& jq >= SIZE_W'(1) && jq + SIZE_W'(1) < sy
		&& (!three_d_q || (kq >= SIZE_W'(1) && kq + SIZE_W'(1) < sz));
	assign hit  = valid_div && inner && fq;
	assign dval = hit ? dsum : '0;
	assign absv = dval[DIV_W-1] ? DIV_W'(-dval) : DIV_W'(dval);
	assign new_sum = sum_q + SUM_W'(absv);
	assign new_cnt = cnt_q + CNT_W'(hit);
	assign last = ix == sx - SIZE_W'(1) && SIZE_W'(py_q) == sy - SIZE_W'(1)
		&& SIZE_W'(pz_q) == sz - SIZE_W'(1);
	assign div_start = go_calc && last && new_cnt != '0;

	mgdm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (new_sum),
		.divisor  (new_cnt),
		.busy     (div_busy),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q    <= SIZE_W'(64);
			size_y_q    <= SIZE_W'(64);
			size_z_q    <= SIZE_W'(64);
			three_d_q   <= 1'b1;
			state_q     <= S_IDLE;
			div_phase_q <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			pz_q        <= '0;
			widx_q      <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((go_calc && !last) || finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_SIZE_X:  size_x_q  <= pwdata[SIZE_W-1:0];
					REG_SIZE_Y:  size_y_q  <= pwdata[SIZE_W-1:0];
					REG_SIZE_Z:  size_z_q  <= pwdata[SIZE_W-1:0];
					REG_THREE_D: three_d_q <= pwdata[0];
					default:     three_d_q <= three_d_q;
				endcase
				px_q   <= '0;
				py_q   <= '0;
				pz_q   <= '0;
				widx_q <= '0;
				sum_q  <= '0;
				cnt_q  <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_RB;
				end
				S_RB:    state_q <= S_RC;
				S_RC:    state_q <= S_CALC;
				default: begin
					if (go_calc) begin
						widx_q <= addr_b;
						if (last) begin
							div_phase_q <= 1'b1;
							px_q  <= '0;
							py_q  <= '0;
							pz_q  <= '0;
							sum_q <= '0;
							cnt_q <= '0;
						end else begin
							state_q     <= S_IDLE;
							sum_q       <= new_sum;
							cnt_q       <= new_cnt;
							if (ix == sx - SIZE_W'(1)) begin
								px_q <= '0;
								if (SIZE_W'(py_q) == sy - SIZE_W'(1)) begin
									py_q <= '0;
									pz_q <= pz_q + CZ_W'(1);
								end else begin
									py_q <= py_q + CY_W'(1);
								end
							end else begin
								px_q <= px_q + CX_W'(1);
							end
						end
					end
					if (finish) begin
						div_phase_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= vel_x;
			cy_q <= vel_y;
			cz_q <= vel_z;
			cf_q <= is_fluid;
		end
		if (state_q == S_RB)
			wa_q <= rdata;
		if (state_q == S_RC)
			wb_q <= rdata;
		if (go_calc) begin
			div_valid_q  <= valid_div;
			divergence_q <= dval;
			grid_done_q  <= last;
			no_fluid_q   <= last && new_cnt == '0;
			mean_q       <= '0;
		end
		if (finish && !no_fluid_q)
			mean_q <= quot[MEAN_W-1:0];
	end

	assign out_valid           = out_valid_q;
	assign div_valid           = div_valid_q;
	assign divergence          = divergence_q;
	assign grid_done           = grid_done_q;
	assign mean_abs_divergence = mean_q;
	assign no_fluid            = no_fluid_q;
endmodule
